// ===== sv/lpc_pkg.sv =====
// Shared types, codes and helpers for the packed ASCII line printer controller.
// No dependencies; imported by every lpc_* module and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lpc_pkg;

  localparam int unsigned LINE_CHARS_DEF = 132;
  localparam int unsigned LANES          = 5;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned WORD_W         = 18;
  localparam int unsigned COL_W          = 8;
  localparam int unsigned LINES_W        = 9;
  localparam int unsigned FEED_W         = 5;
  localparam int unsigned CNT_W          = 3;

  typedef enum logic [2:0] {
    ACT_DATA        = 3'd0,
    ACT_START_LINES = 3'd1,
    ACT_START_ONE   = 3'd2,
    ACT_CLR_DONE    = 3'd3,
    ACT_CLR_FLAGS   = 3'd4,
    ACT_INT_ON      = 3'd5,
    ACT_INT_OFF     = 3'd6,
    ACT_READ        = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    KIND_STATUS   = 2'd0,
    KIND_PRINT    = 2'd1,
    KIND_LINE_END = 2'd2,
    KIND_DROPPED  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    EFF_FEED = 2'd0,
    EFF_FORM = 2'd1,
    EFF_CR   = 2'd2
  } effect_t;

  // Control characters recognised as line ends
  localparam logic [CHAR_W-1:0] CH_LF   = 7'o012;
  localparam logic [CHAR_W-1:0] CH_VT   = 7'o013;
  localparam logic [CHAR_W-1:0] CH_FF   = 7'o014;
  localparam logic [CHAR_W-1:0] CH_CR   = 7'o015;
  localparam logic [CHAR_W-1:0] CH_DLE  = 7'o020;
  localparam logic [CHAR_W-1:0] CH_DC1  = 7'o021;
  localparam logic [CHAR_W-1:0] CH_DC2  = 7'o022;
  localparam logic [CHAR_W-1:0] CH_DC3  = 7'o023;
  localparam logic [CHAR_W-1:0] CH_DC4  = 7'o024;
  localparam logic [CHAR_W-1:0] CH_ESC  = 7'o033;

  // Status flag bit positions
  localparam int unsigned FLAG_DONE = 0;
  localparam int unsigned FLAG_OVF  = 1;
  localparam int unsigned FLAG_ALM  = 2;

  // Status word bit positions
  localparam int unsigned SW_ERR  = 17;
  localparam int unsigned SW_ALM  = 16;
  localparam int unsigned SW_OVF  = 15;
  localparam int unsigned SW_BUSY = 13;
  localparam int unsigned SW_DONE = 12;

  typedef struct packed {
    logic                is_ctrl;
    logic [FEED_W-1:0]   feed;
    effect_t             effect;
  } ctrl_t;

  typedef struct packed {
    logic [2:0]          flags;
    logic                int_en;
    logic                unpacked;
    logic [LINES_W-1:0]  lines_left;
    logic [COL_W-1:0]    line_pos;
    logic                prev_ready;
  } lpc_state_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   char_code;
    kind_t               kind;
    logic [FEED_W-1:0]   feed;
    effect_t             effect;
    logic [COL_W-1:0]    column;
    logic [WORD_W-1:0]   status;
    logic                skip;
    logic                irq;
    logic                last;
  } res_t;

  function automatic logic [WORD_W-1:0] status_value(input logic [2:0] flags,
                                                     input logic [LINES_W-1:0] ll);
    logic [WORD_W-1:0] s;
    s          = '0;
    s[SW_ERR]  = flags[FLAG_ALM] | flags[FLAG_OVF];
    s[SW_ALM]  = flags[FLAG_ALM];
    s[SW_OVF]  = flags[FLAG_OVF];
    s[SW_BUSY] = |ll;
    s[SW_DONE] = flags[FLAG_DONE];
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lpc_lane.sv =====
// One character lane: decodes a seven-bit character against the control table.
// Depends on lpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpc_lane (
  input  wire logic [lpc_pkg::CHAR_W-1:0] char_in,
  output lpc_pkg::ctrl_t                  info
);
  import lpc_pkg::*;

  always_comb begin
    info.is_ctrl = 1'b1;
    info.feed    = '0;
    info.effect  = EFF_FEED;
    unique case (char_in)
      CH_LF:   info.feed = 5'd1;
      CH_VT:   info.feed = 5'd20;
      CH_FF:   info.effect = EFF_FORM;
      CH_CR:   info.effect = EFF_CR;
      CH_DLE:  info.feed = 5'd30;
      CH_DC1:  info.feed = 5'd2;
      CH_DC2:  info.feed = 5'd3;
      CH_DC3:  info.feed = 5'd1;
      CH_DC4:  info.feed = 5'd10;
      CH_ESC:  info.effect = EFF_CR;
      default: info.is_ctrl = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/lpc_merge.sv =====
// Merging stage: walks the lane results in order, tracks column, overflow and
// line count, and builds the result set plus the next controller state. Uses lpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpc_merge #(
  parameter int unsigned LINE_CHARS = lpc_pkg::LINE_CHARS_DEF
) (
  input  wire logic [2:0]                 action,
  input  wire logic [lpc_pkg::WORD_W-1:0] word_first,
  input  wire logic                       printer_ready,
  input  wire logic [lpc_pkg::CHAR_W-1:0] chars [lpc_pkg::LANES],
  input  wire lpc_pkg::ctrl_t             lane_info [lpc_pkg::LANES],
  input  wire lpc_pkg::lpc_state_t        st,
  output lpc_pkg::lpc_state_t             st_next,
  output lpc_pkg::res_t                   res [lpc_pkg::LANES],
  output logic [lpc_pkg::CNT_W-1:0]       res_cnt
);
  import lpc_pkg::*;

  logic [2:0]         flags;
  logic [LINES_W-1:0] ll;
  logic [COL_W-1:0]   pos;
  logic               int_en;
  logic               mode;
  logic               saw;
  logic               chars_on;
  logic [CNT_W-1:0]   n;
  kind_t              kind;

  always_comb begin
    flags    = st.flags;
    ll       = st.lines_left;
    pos      = st.line_pos;
    int_en   = st.int_en;
    mode     = st.unpacked;
    saw      = 1'b0;
    chars_on = 1'b0;
    n        = CNT_W'(1);
    kind     = KIND_STATUS;
    for (int i = 0; i < LANES; i++) res[i] = '0;

    // printer online/offline edge drives alarm
    if (printer_ready != st.prev_ready) flags[FLAG_ALM] = ~printer_ready;

    unique case (action_t'(action))
      ACT_START_LINES, ACT_START_ONE: begin
        mode = word_first[0];
        ll   = (action_t'(action) == ACT_START_ONE) ? LINES_W'(1)
                                                    : {1'b0, word_first[16:9]};
        if (ll == '0) ll = LINES_W'(256);
        pos  = '0;
      end
      ACT_CLR_DONE:  flags[FLAG_DONE] = 1'b0;
      ACT_CLR_FLAGS: flags = flags & (3'b1 << FLAG_ALM);
      ACT_INT_ON:    int_en = 1'b1;
      ACT_INT_OFF:   int_en = 1'b0;
      ACT_READ:      ;
      ACT_DATA: begin
        if (ll != '0) begin
          if (!printer_ready) begin
            flags[FLAG_DONE] = 1'b1;
            flags[FLAG_ALM]  = 1'b1;
            ll = '0;
          end else begin
            chars_on = 1'b1;
          end
        end
      end
    endcase

    if (chars_on) begin
      n = mode ? CNT_W'(2) : CNT_W'(LANES);
      for (int i = 0; i < LANES; i++) begin
        if (CNT_W'(i) < n) begin
          if (lane_info[i].is_ctrl) begin
            kind = KIND_LINE_END;
            pos  = '0;
            saw  = 1'b1;
          end else if (pos < COL_W'(LINE_CHARS)) begin
            kind = KIND_PRINT;
            pos  = pos + COL_W'(1);
          end else begin
            kind = KIND_DROPPED;
            flags[FLAG_OVF] = 1'b1;
          end
          // one line-count decrement per pair, on its final character
          if ((CNT_W'(i) == n - CNT_W'(1)) && saw) begin
            ll = ll - LINES_W'(1);
            if (ll == '0) flags[FLAG_DONE] = 1'b1;
          end
          res[i].char_code = chars[i];
          res[i].kind      = kind;
          res[i].feed      = lane_info[i].feed;
          res[i].effect    = lane_info[i].effect;
          res[i].column    = pos;
          res[i].status    = status_value(flags, ll);
          res[i].skip      = (flags[FLAG_ALM] | flags[FLAG_OVF]) | flags[FLAG_DONE];
          res[i].irq       = int_en & flags[FLAG_DONE];
          res[i].last      = (CNT_W'(i) == n - CNT_W'(1));
        end
      end
    end else begin
      res[0].char_code = '0;
      res[0].kind      = KIND_STATUS;
      res[0].feed      = '0;
      res[0].effect    = EFF_FEED;
      res[0].column    = pos;
      res[0].status    = status_value(flags, ll);
      res[0].skip      = (flags[FLAG_ALM] | flags[FLAG_OVF]) | flags[FLAG_DONE];
      res[0].irq       = int_en & flags[FLAG_DONE];
      res[0].last      = 1'b1;
    end

    res_cnt             = n;
    st_next.flags       = flags;
    st_next.int_en      = int_en;
    st_next.unpacked    = mode;
    st_next.lines_left  = ll;
    st_next.line_pos    = pos;
    st_next.prev_ready  = printer_ready;
  end

endmodule

`default_nettype wire

// ===== sv/lpc_outbuf.sv =====
// Two-deep result-set buffer: one set drains a result per cycle while
// out_ready is high, while the next set waits. Uses lpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpc_outbuf (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire lpc_pkg::res_t              push_res [lpc_pkg::LANES],
  input  wire logic [lpc_pkg::CNT_W-1:0]  push_cnt,
  output logic                            space,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output lpc_pkg::res_t                   out_res
);
  import lpc_pkg::*;

  logic             cur_valid;
  logic [CNT_W-1:0] cur_cnt;
  logic [CNT_W-1:0] cur_idx;
  res_t             cur_res [LANES];
  logic             nxt_valid;
  logic [CNT_W-1:0] nxt_cnt;
  res_t             nxt_res [LANES];

  logic pop;
  logic last_pop;
  logic frees;

  assign space     = ~nxt_valid;
  assign out_valid = cur_valid;
  assign out_res   = cur_res[cur_idx];
  assign pop       = cur_valid & out_ready;
  assign last_pop  = pop && (cur_idx == cur_cnt - CNT_W'(1));
  assign frees     = ~cur_valid | last_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      nxt_valid <= 1'b0;
      cur_idx   <= '0;
    end else begin
      if (frees) begin
        cur_idx <= '0;
        if (nxt_valid) begin
          cur_valid <= 1'b1;
          cur_cnt   <= nxt_cnt;
          cur_res   <= nxt_res;
          nxt_valid <= 1'b0;
        end else if (push) begin
          cur_valid <= 1'b1;
          cur_cnt   <= push_cnt;
          cur_res   <= push_res;
        end else begin
          cur_valid <= 1'b0;
        end
      end else begin
        if (pop) cur_idx <= cur_idx + CNT_W'(1);
        if (push) begin
          nxt_valid <= 1'b1;
          nxt_cnt   <= push_cnt;
          nxt_res   <= push_res;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/packed_ascii_line_printer_ctrl_top.sv =====
// Line printer controller for an 18-bit machine: command decode, character
// unpacking over parallel lanes and result buffering.
// Depends on lpc_pkg, lpc_lane, lpc_merge and lpc_outbuf.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one action per transfer:
//    a data pair, a start, a flag clear, an interrupt enable change or a
//    status read, together with printer_ready.
//  - Output channel (out_valid/out_ready) returns the results of each action
//    in order: one status-only result for a command, two (unpacked) or five
//    (packed) character results for a data pair while busy and the printer is
//    ready. 'last' marks the final result of each action.
//  - Output: the result set of an action is registered on its input
//    transfer. Results leave one per cycle while out_ready is high, so an
//    action occupies the output for 1, 2 or 5 results; that output port is
//    the rate limit.
//  - All five lanes decode their character in the transfer cycle; the merge
//    stage resolves column, overflow and line count in character order and
//    the whole result set is registered at once.
//  - A second result set can be held while the first drains; in_ready only
//    drops when both are occupied, e.g. when the receiver stalls.
//  - Reset: flags, line count, column and mode cleared, interrupt enable set,
//    no results pending.
`timescale 1ns / 1ps
`default_nettype none

module packed_ascii_line_printer_ctrl_top #(
  parameter int unsigned LINE_CHARS = lpc_pkg::LINE_CHARS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  action,
  input  wire logic [lpc_pkg::WORD_W-1:0]  word_first,
  input  wire logic [lpc_pkg::WORD_W-1:0]  word_second,
  input  wire logic                        printer_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [lpc_pkg::CHAR_W-1:0]       char_code,
  output logic [1:0]                       char_kind,
  output logic [lpc_pkg::FEED_W-1:0]       feed_lines,
  output logic [1:0]                       control_effect,
  output logic [lpc_pkg::COL_W-1:0]        column,
  output logic [lpc_pkg::WORD_W-1:0]       status_word,
  output logic                             skip,
  output logic                             irq,
  output logic                             last
);
  import lpc_pkg::*;

  // Controller state, committed on every input transfer
  lpc_state_t       st;
  lpc_state_t       st_next;

  logic [CHAR_W-1:0] chars [LANES];
  ctrl_t             lane_info [LANES];
  res_t              res_set [LANES];
  logic [CNT_W-1:0]  res_cnt;
  res_t              out_res;
  logic              in_xfer;

  assign in_xfer = in_valid & in_ready;

  // Character split: unpacked mode uses the low seven bits of each word,
  // packed mode spreads five characters over the 36-bit pair.
  always_comb begin
    for (int i = 0; i < LANES; i++) chars[i] = '0;
    if (st.unpacked) begin
      chars[0] = word_first[6:0];
      chars[1] = word_second[6:0];
    end else begin
      chars[0] = word_first[17:11];
      chars[1] = word_first[10:4];
      chars[2] = {word_first[3:0], word_second[17:15]};
      chars[3] = word_second[14:8];
      chars[4] = word_second[7:1];
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    lpc_lane u_lane (
      .char_in (chars[g]),
      .info    (lane_info[g])
    );
  end

  lpc_merge #(
    .LINE_CHARS (LINE_CHARS)
  ) u_merge (
    .action        (action),
    .word_first    (word_first),
    .printer_ready (printer_ready),
    .chars         (chars),
    .lane_info     (lane_info),
    .st            (st),
    .st_next       (st_next),
    .res           (res_set),
    .res_cnt       (res_cnt)
  );

  lpc_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_xfer),
    .push_res  (res_set),
    .push_cnt  (res_cnt),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.flags      <= '0;
      st.int_en     <= 1'b1;
      st.unpacked   <= 1'b0;
      st.lines_left <= '0;
      st.line_pos   <= '0;
      st.prev_ready <= 1'b0;
    end else if (in_xfer) begin
      st <= st_next;
    end
  end

  assign char_code      = out_res.char_code;
  assign char_kind      = out_res.kind;
  assign feed_lines     = out_res.feed;
  assign control_effect = out_res.effect;
  assign column         = out_res.column;
  assign status_word    = out_res.status;
  assign skip           = out_res.skip;
  assign irq            = out_res.irq;
  assign last           = out_res.last;

endmodule

`default_nettype wire

// ===== bench/lpc_print_checker.sv =====
// Result checker for the packed ASCII line printer controller: watches both channels,
// predicts the results of every accepted action and compares them in order.
// Depends on lpc_pkg for result, kind and effect types and the control codes.
`timescale 1ns / 1ps

module lpc_print_checker #(
  parameter int unsigned LINE_CHARS = lpc_pkg::LINE_CHARS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [2:0]                  action,
  input  wire logic [lpc_pkg::WORD_W-1:0]  word_first,
  input  wire logic [lpc_pkg::WORD_W-1:0]  word_second,
  input  wire logic                        printer_ready,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [lpc_pkg::CHAR_W-1:0]  char_code,
  input  wire logic [1:0]                  char_kind,
  input  wire logic [lpc_pkg::FEED_W-1:0]  feed_lines,
  input  wire logic [1:0]                  control_effect,
  input  wire logic [lpc_pkg::COL_W-1:0]   column,
  input  wire logic [lpc_pkg::WORD_W-1:0]  status_word,
  input  wire logic                        skip,
  input  wire logic                        irq,
  input  wire logic                        last,
  output int                               fail_count,
  output int                               pending
);

  import lpc_pkg::*;

  localparam int MAX_PRINTED = 100;

  // predicted controller state
  logic [2:0]         flags;
  logic               int_en;
  logic               unpacked;
  logic [LINES_W-1:0] lines_left;
  logic [COL_W-1:0]   line_pos;
  logic               prev_rdy;

  res_t expected_chars[$];
  int   results_seen;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTED)
      $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got 'h%0h, expected 'h%0h",
                                results_seen, name, got, want));
  endtask

  function automatic logic [WORD_W-1:0] status_snapshot();
    logic [WORD_W-1:0] s;
    s          = '0;
    s[SW_ERR]  = flags[FLAG_ALM] | flags[FLAG_OVF];
    s[SW_ALM]  = flags[FLAG_ALM];
    s[SW_OVF]  = flags[FLAG_OVF];
    s[SW_BUSY] = (lines_left != '0);
    s[SW_DONE] = flags[FLAG_DONE];
    return s;
  endfunction

  // line end decode: feed count and effect, both zero for other codes
  function automatic logic line_end_code(input logic [CHAR_W-1:0] c,
                                         output logic [FEED_W-1:0] feed,
                                         output effect_t eff);
    logic hit;
    hit  = 1'b1;
    feed = '0;
    eff  = EFF_FEED;
    case (c)
      CH_LF:   feed = 5'd1;
      CH_VT:   feed = 5'd20;
      CH_FF:   eff  = EFF_FORM;
      CH_CR:   eff  = EFF_CR;
      CH_DLE:  feed = 5'd30;
      CH_DC1:  feed = 5'd2;
      CH_DC2:  feed = 5'd3;
      CH_DC3:  feed = 5'd1;
      CH_DC4:  feed = 5'd10;
      CH_ESC:  eff  = EFF_CR;
      default: hit  = 1'b0;
    endcase
    return hit;
  endfunction

  task automatic queue_result(input logic [CHAR_W-1:0] code, input kind_t kind,
                              input logic [FEED_W-1:0] feed, input effect_t eff,
                              input logic is_last);
    res_t r;
    logic [WORD_W-1:0] s;
    s          = status_snapshot();
    r.char_code = code;
    r.kind      = kind;
    r.feed      = feed;
    r.effect    = eff;
    r.column    = line_pos;
    r.status    = s;
    r.skip      = s[SW_ERR] | s[SW_DONE];
    r.irq       = int_en & flags[FLAG_DONE];
    r.last      = is_last;
    expected_chars.push_back(r);
  endtask

  task automatic predict_action(input logic [2:0] act, input logic [WORD_W-1:0] w0,
                                input logic [WORD_W-1:0] w1, input logic rdy);
    logic [CHAR_W-1:0] chars [5];
    int                n;
    logic [FEED_W-1:0] feed;
    effect_t           eff;
    kind_t             kind;
    logic              saw_end;
    logic              printed;
    saw_end = 1'b0;
    printed = 1'b0;
    // alarm follows edges of the printer ready line
    if (rdy != prev_rdy)
      flags[FLAG_ALM] = ~rdy;
    prev_rdy = rdy;
    case (act)
      ACT_START_LINES, ACT_START_ONE: begin
        unpacked   = w0[0];
        lines_left = (act == ACT_START_ONE) ? LINES_W'(1) : {1'b0, w0[16:9]};
        if (lines_left == '0)
          lines_left = LINES_W'(256);
        line_pos = '0;
      end
      ACT_CLR_DONE:  flags[FLAG_DONE] = 1'b0;
      ACT_CLR_FLAGS: begin
        flags[FLAG_DONE] = 1'b0;
        flags[FLAG_OVF]  = 1'b0;
      end
      ACT_INT_ON:    int_en = 1'b1;
      ACT_INT_OFF:   int_en = 1'b0;
      ACT_DATA: begin
        if (lines_left != '0) begin
          if (!rdy) begin
            flags[FLAG_DONE] = 1'b1;
            flags[FLAG_ALM]  = 1'b1;
            lines_left       = '0;
          end else begin
            if (unpacked) begin
              chars[0] = w0[6:0];
              chars[1] = w1[6:0];
              n = 2;
            end else begin
              chars[0] = w0[17:11];
              chars[1] = w0[10:4];
              chars[2] = {w0[3:0], w1[17:15]};
              chars[3] = w1[14:8];
              chars[4] = w1[7:1];
              n = 5;
            end
            for (int i = 0; i < n; i++) begin
              if (line_end_code(chars[i], feed, eff)) begin
                kind     = KIND_LINE_END;
                line_pos = '0;
                saw_end  = 1'b1;
              end else if (line_pos < LINE_CHARS) begin
                kind     = KIND_PRINT;
                line_pos = line_pos + 1'b1;
              end else begin
                kind            = KIND_DROPPED;
                flags[FLAG_OVF] = 1'b1;
              end
              // line count drops once per pair, before the final result
              if (i == n - 1 && saw_end) begin
                lines_left = lines_left - 1'b1;
                if (lines_left == '0)
                  flags[FLAG_DONE] = 1'b1;
              end
              queue_result(chars[i], kind, feed, eff, i == n - 1);
            end
            printed = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (!printed)
      queue_result('0, KIND_STATUS, '0, EFF_FEED, 1'b1);
  endtask

  always @(posedge clk) begin : monitor
    res_t want;
    if (rst) begin
      flags      = '0;
      int_en     = 1'b1;
      unpacked   = 1'b0;
      lines_left = '0;
      line_pos   = '0;
      prev_rdy   = 1'b0;
      expected_chars.delete();
      pending <= 0;
    end else begin
      // results first: a result leaving now belongs to an earlier action
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("result %0d with none expected, code 'h%0h",
                                    results_seen, char_code));
        end else begin
          want = expected_chars.pop_front();
          check_field("char_code", WORD_W'(char_code), WORD_W'(want.char_code));
          check_field("char_kind", WORD_W'(char_kind), WORD_W'(want.kind));
          check_field("feed_lines", WORD_W'(feed_lines), WORD_W'(want.feed));
          check_field("control_effect", WORD_W'(control_effect),
                      WORD_W'(want.effect));
          check_field("column", WORD_W'(column), WORD_W'(want.column));
          check_field("status_word", status_word, want.status);
          check_field("skip", WORD_W'(skip), WORD_W'(want.skip));
          check_field("irq", WORD_W'(irq), WORD_W'(want.irq));
          check_field("last", WORD_W'(last), WORD_W'(want.last));
        end
        results_seen++;
      end
      if (in_valid && in_ready)
        predict_action(action, word_first, word_second, printer_ready);
      pending <= expected_chars.size();
    end
  end

endmodule

// ===== bench/packed_ascii_line_printer_ctrl_top_test.sv =====
// Testbench top for the packed ASCII line printer controller: clock, reset,
// directed and random action stimulus, receiver stalls, watchdog and verdict.
// Depends on lpc_pkg, packed_ascii_line_printer_ctrl_top and lpc_print_checker.
`timescale 1ns / 1ps

module packed_ascii_line_printer_ctrl_top_test;

  import lpc_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 176;
  // cycles with no transfer on either channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  // quiet cycles after the last result
  localparam int DRAIN_CYCLES   = 10;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                in_valid      = 1'b0;
  logic [2:0]          action        = ACT_READ;
  logic [WORD_W-1:0]   word_first    = '0;
  logic [WORD_W-1:0]   word_second   = '0;
  logic                printer_ready = 1'b0;
  logic                out_ready     = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [CHAR_W-1:0]   char_code;
  logic [1:0]          char_kind;
  logic [FEED_W-1:0]   feed_lines;
  logic [1:0]          control_effect;
  logic [COL_W-1:0]    column;
  logic [WORD_W-1:0]   status_word;
  logic                skip;
  logic                irq;
  logic                last;

  int fail_count;
  int results_pending;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int items_sent         = 0;
  int quiet_cycles       = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  packed_ascii_line_printer_ctrl_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .word_first     (word_first),
    .word_second    (word_second),
    .printer_ready  (printer_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .char_code      (char_code),
    .char_kind      (char_kind),
    .feed_lines     (feed_lines),
    .control_effect (control_effect),
    .column         (column),
    .status_word    (status_word),
    .skip           (skip),
    .irq            (irq),
    .last           (last)
  );

  // The checker sits beside the block on both channels and keeps the
  // expected results; the top only drives and judges.
  lpc_print_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .word_first     (word_first),
    .word_second    (word_second),
    .printer_ready  (printer_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .char_code      (char_code),
    .char_kind      (char_kind),
    .feed_lines     (feed_lines),
    .control_effect (control_effect),
    .column         (column),
    .status_word    (status_word),
    .skip           (skip),
    .irq            (irq),
    .last           (last),
    .fail_count     (fail_count),
    .pending        (results_pending)
  );

  // Receiver: a fresh stall decision every cycle at the current stall rate.
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);

  // Watchdog: counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("** packed_ascii_line_printer_ctrl_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One action transfer. Idle cycles go in front at the sender's idle rate;
  // once raised, valid and payload hold until the edge that takes them.
  // in_ready is read just after the edge, so it is the value the edge saw.
  task automatic send_action(input action_t act, input logic [WORD_W-1:0] w0,
                             input logic [WORD_W-1:0] w1, input logic rdy);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    word_first    <= w0;
    word_second   <= w1;
    printer_ready <= rdy;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    items_sent++;
  endtask

  // Hold the sender back until every expected result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0)
      @(posedge clk);
  endtask

  // Packed layout: five 7-bit characters, first in the top of word_first,
  // the third straddling the two words, bit 0 of word_second unused.
  function automatic logic [2*WORD_W-1:0] pack_pair(
      input logic [CHAR_W-1:0] c0, input logic [CHAR_W-1:0] c1,
      input logic [CHAR_W-1:0] c2, input logic [CHAR_W-1:0] c3,
      input logic [CHAR_W-1:0] c4, input logic spare);
    return {c0, c1, c2[6:3], c2[2:0], c3, c4, spare};
  endfunction

  // Random character; ctrl_pct biases towards the line end codes, and
  // printable_only keeps to plain text so that a line can fill up.
  function automatic logic [CHAR_W-1:0] pick_char(input int ctrl_pct,
                                                  input bit printable_only);
    logic [CHAR_W-1:0] c;
    if (printable_only) begin
      c = CHAR_W'($urandom_range(126, 32));
    end else if ($urandom_range(99) < ctrl_pct) begin
      case ($urandom_range(9))
        0:       c = CH_LF;
        1:       c = CH_VT;
        2:       c = CH_FF;
        3:       c = CH_CR;
        4:       c = CH_DLE;
        5:       c = CH_DC1;
        6:       c = CH_DC2;
        7:       c = CH_DC3;
        8:       c = CH_DC4;
        default: c = CH_ESC;
      endcase
    end else begin
      c = CHAR_W'($urandom_range(127));
    end
    return c;
  endfunction

  // One data pair in the given mode with random filler in the unused bits.
  task automatic send_data(input logic unpacked, input int ctrl_pct,
                           input bit printable_only, input logic rdy);
    logic [WORD_W-1:0]   w0;
    logic [WORD_W-1:0]   w1;
    logic [2*WORD_W-1:0] pair;
    if (unpacked) begin
      w0      = WORD_W'($urandom());
      w1      = WORD_W'($urandom());
      w0[6:0] = pick_char(ctrl_pct, printable_only);
      w1[6:0] = pick_char(ctrl_pct, printable_only);
    end else begin
      pair = pack_pair(pick_char(ctrl_pct, printable_only),
                       pick_char(ctrl_pct, printable_only),
                       pick_char(ctrl_pct, printable_only),
                       pick_char(ctrl_pct, printable_only),
                       pick_char(ctrl_pct, printable_only), 1'($urandom_range(1)));
      {w0, w1} = pair;
    end
    send_action(ACT_DATA, w0, w1, rdy);
  endtask

  // A well-formed print job: a start, then a run of data pairs, with the
  // odd offline pair thrown in to abort it, and at times a clear of done afterwards.
  task automatic run_print_job();
    logic [WORD_W-1:0] hdr;
    logic              mode;
    int                pairs;
    int                ctrl_pct;
    mode      = 1'($urandom_range(1));
    hdr       = WORD_W'($urandom());
    hdr[16:9] = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(4, 1));
    hdr[0]    = mode;
    case ($urandom_range(2))
      0:       ctrl_pct = 5;
      1:       ctrl_pct = 20;
      default: ctrl_pct = 40;
    endcase
    pairs = $urandom_range(10, 2);
    send_action(($urandom_range(3) == 0) ? ACT_START_ONE : ACT_START_LINES, hdr,
                WORD_W'($urandom()), 1'b1);
    repeat (pairs)
      send_data(mode, ctrl_pct, 1'b0, ($urandom_range(99) >= 4));
    if ($urandom_range(1))
      send_action(ACT_CLR_DONE, WORD_W'($urandom()), WORD_W'($urandom()), 1'b1);
  endtask

  // A single line of plain text long enough to run past the last column,
  // closed by a pair rich in line end codes.
  task automatic run_long_line();
    send_action(ACT_START_ONE, 18'o000000, WORD_W'($urandom()), 1'b1);
    repeat (30)
      send_data(1'b0, 0, 1'b1, 1'b1);
    send_data(1'b0, 60, 1'b0, 1'b1);
  endtask

  // Noise: any action with random words, printer now and then offline.
  task automatic run_noise();
    repeat ($urandom_range(4, 1))
      send_action(action_t'($urandom_range(7)), WORD_W'($urandom()),
                  WORD_W'($urandom()), ($urandom_range(99) < 85));
  endtask

  initial begin
    logic [2*WORD_W-1:0] pair;
    int                  phase_start;
    int                  roll;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // printer offline from reset: no edge, nothing flagged
    send_action(ACT_READ, '0, '0, 1'b0);
    // rise of ready; all-ones words are ignored by a status read
    send_action(ACT_READ, '1, '1, 1'b1);
    // fall of ready raises alarm
    send_action(ACT_INT_OFF, '0, '0, 1'b0);
    send_action(ACT_INT_ON, '0, '0, 1'b1);
    // data while no lines are requested: status only
    send_action(ACT_DATA, '1, '1, 1'b1);
    // single-line start ignores the header count; packed mode
    send_action(ACT_START_ONE, 18'o777776, '0, 1'b1);
    // both extreme codes print, the line feed ends the only line -> done
    pair = pack_pair(7'h48, 7'h00, 7'h7f, 7'h49, CH_LF, 1'b1);
    send_action(ACT_DATA, pair[35:18], pair[17:0], 1'b1);
    // done and no lines left: status only
    pair = pack_pair(7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 1'b0);
    send_action(ACT_DATA, pair[35:18], pair[17:0], 1'b1);
    send_action(ACT_CLR_DONE, '0, '0, 1'b1);
    // count field of zero means 256 lines; unpacked, top bit set
    send_action(ACT_START_LINES, 18'o400001, '1, 1'b1);
    send_action(ACT_DATA, {11'h7ff, 7'h41}, {11'h000, CH_CR}, 1'b1);
    send_action(ACT_DATA, {11'h000, 7'h7f}, {11'h7ff, 7'h00}, 1'b1);
    // printer goes offline mid job: abort, done and alarm
    send_action(ACT_DATA, {11'h000, 7'h41}, {11'h000, 7'h42}, 1'b0);
    // flag clear keeps the alarm
    send_action(ACT_CLR_FLAGS, '0, '0, 1'b0);
    // largest explicit count, packed; ready rises again
    send_action(ACT_START_LINES, {1'b0, 8'hff, 9'h000}, '0, 1'b1);
    // every line end code once
    pair = pack_pair(CH_LF, CH_VT, CH_FF, CH_CR, CH_DLE, 1'b0);
    send_action(ACT_DATA, pair[35:18], pair[17:0], 1'b1);
    pair = pack_pair(CH_DC1, CH_DC2, CH_DC3, CH_DC4, CH_ESC, 1'b1);
    send_action(ACT_DATA, pair[35:18], pair[17:0], 1'b1);
    // two line ends in one pair, text after each starts a new line
    pair = pack_pair(7'h41, CH_CR, 7'h42, CH_LF, 7'h43, 1'b0);
    send_action(ACT_DATA, pair[35:18], pair[17:0], 1'b1);
    // done with interrupts off, then on: irq follows the enable
    send_action(ACT_INT_OFF, '0, '0, 1'b1);
    send_action(ACT_START_ONE, 18'o000001, '0, 1'b1);
    send_action(ACT_DATA, {11'h555, 7'h5a}, {11'h2aa, CH_LF}, 1'b1);
    send_action(ACT_READ, '0, '0, 1'b1);
    send_action(ACT_INT_ON, '0, '0, 1'b1);
    send_action(ACT_CLR_FLAGS, '1, '1, 1'b1);
    wait_for_results();

    // ---- random part, four flow-control phases ----
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 48;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 48;
        end
        default: begin
          sender_idle_pct    = 28;
          receiver_stall_pct = 28;
        end
      endcase
      phase_start = items_sent;
      // overflow needs one full line; make sure it happens early
      if (phase == 0)
        run_long_line();
      while (items_sent - phase_start < RANDOM_ITEMS / 4) begin
        roll = $urandom_range(99);
        if (roll < 6)
          run_long_line();
        else if (roll < 72)
          run_print_job();
        else
          run_noise();
      end
      // sender pauses until the checker has nothing outstanding
      wait_for_results();
    end

    // ---- end of run ----
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("** packed_ascii_line_printer_ctrl_top: PASSED **");
    end else begin
      $display("** packed_ascii_line_printer_ctrl_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lpc_pkg.sv
sv/lpc_lane.sv
sv/lpc_merge.sv
sv/lpc_outbuf.sv
sv/packed_ascii_line_printer_ctrl_top.sv
bench/lpc_print_checker.sv
bench/packed_ascii_line_printer_ctrl_top_test.sv
